@@ sv/kpeg_pkg.sv @@
// ----------------------------------------------------------------------------
// kpeg_pkg: shared constants, types and helpers of the Kronecker power entry
// generator.
// ----------------------------------------------------------------------------
package kpeg_pkg;

  localparam int MaxOrder = 6;
  localparam int IdxW     = 10;
  localparam int DigW     = 2;
  localparam int EntW     = 3;
  localparam int ValW     = 14;
  localparam int OrdW     = 3;
  localparam int RotW     = 27;
  localparam int PermW    = 18;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 27;

  // Register indexes of the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_TENSOR_ORDER     = 2'd0,
    CFG_ROTATION_ENTRIES = 2'd1,
    CFG_PERMUTATION_MAP  = 2'd2
  } cfg_idx_e;

  localparam logic [OrdW-1:0]  OrderReset = 3'd1;
  localparam logic [RotW-1:0]  RotReset   = 27'd16781313;
  localparam logic [PermW-1:0] PermReset  = 18'd181896;

  // Base-3 digits of one index, least significant digit in element 0.
  typedef logic [MaxOrder-1:0][DigW-1:0] digits_t;

  // Three base-3 digits of a value below 64, least significant first.
  // Division by three is a multiply by 43 and a shift by seven, exact here.
  function automatic logic [2:0][DigW-1:0] split3(input logic [5:0] v);
    logic [5:0]  cur;
    logic [11:0] prod;
    logic [5:0]  quo;
    logic [5:0]  rem;
    logic [2:0][DigW-1:0] res;
    cur = v;
    for (int i = 0; i < 3; i++) begin
      prod   = 12'(cur) * 12'd43;
      quo    = {1'b0, prod[11:7]};
      rem    = cur - 6'(quo * 6'd3);
      res[i] = rem[DigW-1:0];
      cur    = quo;
    end
    return res;
  endfunction

endpackage

@@ sv/kpeg_index_split.sv @@
// ----------------------------------------------------------------------------
// kpeg_index_split: two-stage base-3 digit extraction of one index.
// Stage one divides by 27, stage two splits quotient and remainder into digits.
// ----------------------------------------------------------------------------
module kpeg_index_split (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [kpeg_pkg::IdxW-1:0]   idx_i,
  output kpeg_pkg::digits_t           digits_o
);

  // Quotient by 27 as a reciprocal multiply: (x * 1214) >> 15 is exact for
  // every 10-bit x.
  logic [20:0] recip_prod;
  logic [5:0]  quo_d, quo_q;
  logic [4:0]  rem_d, rem_q;
  kpeg_pkg::digits_t digits_d, digits_q;

  assign recip_prod = 21'(idx_i) * 21'd1214;
  assign quo_d      = recip_prod[20:15];
  assign rem_d      = 5'(idx_i - 10'(quo_d * 10'd27));

  always_comb begin
    logic [2:0][kpeg_pkg::DigW-1:0] lo;
    logic [2:0][kpeg_pkg::DigW-1:0] hi;
    lo = kpeg_pkg::split3({1'b0, rem_q});
    hi = kpeg_pkg::split3(quo_q);
    digits_d = {hi, lo};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_q    <= quo_d;
      rem_q    <= rem_d;
      digits_q <= digits_d;
    end
  end

  assign digits_o = digits_q;

endmodule

@@ sv/kronecker_power_entry_generator.sv @@
// ----------------------------------------------------------------------------
// kronecker_power_entry_generator: streams nonzero entries of a permuted
// Kronecker power of a 3x3 integer matrix.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                      payload
//  --------  ---------  -----------------------------  -------------------------
//  s_axis    in         s_axis_tvalid / s_axis_tready  row_index, col_index
//  m_axis    out        m_axis_tvalid / m_axis_tready  row_out, col_out, value
//  cfg       in         cfg_valid_i / cfg_ready_o      cfg_index_i, cfg_data_i
//
// One item is accepted every cycle unless the output stalls. The pipe has six
// register stages: the digit split (two stages), the entry lookup and the
// three-level product tree, whose last level is the output register.
// Reset clears the valid bits and loads the identity matrix, order one and
// the straight permutation. A stall at the output freezes every stage at once,
// so nothing is lost or repeated. Items out of range or with a zero product
// leave the pipe as bubbles. The configuration port is always ready.
//
module kronecker_power_entry_generator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Fields from bit 0: row_index[9:0], col_index[19:10], zero fill.
  input  logic [23:0]                   s_axis_tdata,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // Fields from bit 0: row_out[9:0], col_out[19:10], entry_value[33:20], zero fill.
  output logic [39:0]                   m_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [kpeg_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [kpeg_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int IdxW = kpeg_pkg::IdxW;
  localparam int EntW = kpeg_pkg::EntW;
  localparam int ValW = kpeg_pkg::ValW;
  localparam int NOrd = kpeg_pkg::MaxOrder;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [kpeg_pkg::OrdW-1:0]  order_q;
  logic [kpeg_pkg::RotW-1:0]  rot_q;
  logic [kpeg_pkg::PermW-1:0] perm_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= kpeg_pkg::OrderReset;
      rot_q   <= kpeg_pkg::RotReset;
      perm_q  <= kpeg_pkg::PermReset;
    end else if (cfg_valid_i) begin
      case (kpeg_pkg::cfg_idx_e'(cfg_index_i))
        kpeg_pkg::CFG_TENSOR_ORDER:     order_q <= cfg_data_i[kpeg_pkg::OrdW-1:0];
        kpeg_pkg::CFG_ROTATION_ENTRIES: rot_q   <= cfg_data_i[kpeg_pkg::RotW-1:0];
        kpeg_pkg::CFG_PERMUTATION_MAP:  perm_q  <= cfg_data_i[kpeg_pkg::PermW-1:0];
        default: ;
      endcase
    end
  end

  // Orders above the supported maximum behave as the maximum.
  logic [kpeg_pkg::OrdW-1:0] ord_sat;
  assign ord_sat = (order_q > 3'(NOrd)) ? 3'(NOrd) : order_q;

  // Matrix side, three to the order.
  logic [IdxW:0] side;
  always_comb begin
    side = 11'd1;
    for (int k = 0; k < NOrd; k++) begin
      if (3'(k) < ord_sat) side = 11'(side * 11'd3);
    end
  end

  // --------------------------------------------------------------------------
  // Global stall: every stage moves when the output register can take data.
  // --------------------------------------------------------------------------
  logic adv;
  logic m_valid_q;

  assign adv           = !m_valid_q || m_axis_tready;
  assign s_axis_tready = adv;

  logic [IdxW-1:0] in_row, in_col;
  assign in_row = s_axis_tdata[IdxW-1:0];
  assign in_col = s_axis_tdata[2*IdxW-1:IdxW];

  // Stage 1: divide by 27, range check.
  logic            v1_q, ok1_q;
  logic [IdxW-1:0] row1_q, col1_q;
  // Stage 2: digits ready.
  logic            v2_q, ok2_q;
  logic [IdxW-1:0] row2_q, col2_q;
  // Stage 3: selected matrix entries.
  logic                   v3_q;
  logic [IdxW-1:0]        row3_q, col3_q;
  logic signed [EntW-1:0] ent3_q [NOrd];
  // Stage 4: pairwise products.
  logic            v4_q;
  logic [IdxW-1:0] row4_q, col4_q;
  logic signed [5:0] p01_q, p23_q, p45_q;
  // Stage 5: four-factor product.
  logic            v5_q;
  logic [IdxW-1:0] row5_q, col5_q;
  logic signed [9:0] p0123_q;
  logic signed [5:0] p45b_q;
  // Output register.
  logic [IdxW-1:0]        row_o_q, col_o_q;
  logic signed [ValW-1:0] val_o_q;

  kpeg_pkg::digits_t row_dig, col_dig;

  kpeg_index_split u_row_split (
    .clk_i    (clk_i),
    .en_i     (adv),
    .idx_i    (in_row),
    .digits_o (row_dig)
  );

  kpeg_index_split u_col_split (
    .clk_i    (clk_i),
    .en_i     (adv),
    .idx_i    (in_col),
    .digits_o (col_dig)
  );

  // Matrix entries as an array, entry r*3+c.
  logic signed [EntW-1:0] rot_arr [9];
  always_comb begin
    for (int i = 0; i < 9; i++) rot_arr[i] = rot_q[EntW*i +: EntW];
  end

  // Entry selection. Digit k counts from the most significant end, so it sits
  // at least significant position order-1-k. Unused factors read as one.
  logic signed [EntW-1:0] ent_d [NOrd];
  always_comb begin
    logic [2:0] psel;
    logic [2:0] rpos;
    logic [2:0] cpos;
    logic [kpeg_pkg::DigW-1:0] rd;
    logic [kpeg_pkg::DigW-1:0] cd;
    logic [3:0] eidx;
    for (int k = 0; k < NOrd; k++) begin
      psel = perm_q[3*k +: 3];
      if (psel >= ord_sat) psel = 3'd0;
      rpos = ord_sat - 3'(k) - 3'd1;
      cpos = ord_sat - psel - 3'd1;
      rd   = (rpos < 3'(NOrd)) ? row_dig[rpos] : '0;
      cd   = (cpos < 3'(NOrd)) ? col_dig[cpos] : '0;
      eidx = 4'({2'b00, rd} * 4'd3) + {2'b00, cd};
      if (3'(k) < ord_sat) begin
        ent_d[k] = (eidx < 4'd9) ? rot_arr[eidx] : '0;
      end else begin
        ent_d[k] = 3'sd1;
      end
    end
  end

  logic signed [ValW-1:0] prod_d;
  assign prod_d = 14'(p0123_q) * 14'(p45b_q);

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      v4_q      <= 1'b0;
      v5_q      <= 1'b0;
      m_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q      <= s_axis_tvalid;
      v2_q      <= v1_q;
      v3_q      <= v2_q && ok2_q;
      v4_q      <= v3_q;
      v5_q      <= v4_q;
      m_valid_q <= v5_q && (prod_d != '0);
    end
  end

  // Payload.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      row1_q  <= in_row;
      col1_q  <= in_col;
      ok1_q   <= ({1'b0, in_row} < side) && ({1'b0, in_col} < side);
      row2_q  <= row1_q;
      col2_q  <= col1_q;
      ok2_q   <= ok1_q;
      row3_q  <= row2_q;
      col3_q  <= col2_q;
      for (int k = 0; k < NOrd; k++) ent3_q[k] <= ent_d[k];
      row4_q  <= row3_q;
      col4_q  <= col3_q;
      p01_q   <= 6'(ent3_q[0]) * 6'(ent3_q[1]);
      p23_q   <= 6'(ent3_q[2]) * 6'(ent3_q[3]);
      p45_q   <= 6'(ent3_q[4]) * 6'(ent3_q[5]);
      row5_q  <= row4_q;
      col5_q  <= col4_q;
      p0123_q <= 10'(p01_q) * 10'(p23_q);
      p45b_q  <= p45_q;
      row_o_q <= row5_q;
      col_o_q <= col5_q;
      val_o_q <= prod_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {6'd0, val_o_q, col_o_q, row_o_q};

endmodule

@@ sv/kpeg_checker.sv @@
// ----------------------------------------------------------------------------
// kpeg_checker: port-level assertions of the Kronecker power entry generator,
// bound to the top level.
// ----------------------------------------------------------------------------
module kpeg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Zero entries are never emitted.
  a_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[33:20] != 14'd0)
    else $error("zero entry emitted");

  // Emitted positions lie inside the largest matrix.
  a_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[9:0] < 10'd729) && (m_axis_tdata[19:10] < 10'd729))
    else $error("position out of range");

  // Whenever the sink takes data, the input side is open too.
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input blocked while output drains");

endmodule

bind kronecker_power_entry_generator kpeg_checker u_kpeg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);
